@@ sv/text_mode_console_writer_defines.svh @@
// Assertion macros shared by the console writer RTL.
`ifndef TEXT_MODE_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_MODE_CONSOLE_WRITER_DEFINES_SVH

`ifndef SYNTHESIS
// Invariant checked at every clock edge outside reset
`define TMCW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Condition in one cycle implies a result in the next
`define TMCW_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define TMCW_ASSERT(label, prop, msg)
`define TMCW_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

@@ sv/tmcw_pkg.sv @@
// Shared types, constants and field widths for the text mode console writer.
package tmcw_pkg;

	// Default screen geometry
	localparam int COLS_DEF = 80;
	localparam int ROWS_DEF = 24;

	// Field widths
	localparam int OP_W   = 1;
	localparam int CODE_W = 9;
	localparam int IDX_W  = 11;
	localparam int CUR_W  = 11;
	localparam int CELL_W = 16;
	localparam int ATTR_W = 8;
	localparam int CHAR_W = 8;

	// Stream bus widths, padded to whole bytes
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 32;

	// Codes
	localparam logic [OP_W-1:0]   OP_PUT         = 1'b0;
	localparam logic [OP_W-1:0]   OP_READ        = 1'b1;
	localparam logic [CODE_W-1:0] CODE_NEWLINE   = 9'd10;
	localparam logic [CODE_W-1:0] CODE_BACKSPACE = 9'h100;
	localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;
	localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'h07;

	// Controller states
	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_PUT   = 8'b0000_0100,
		ST_BLANK = 8'b0000_1000,
		ST_COPY  = 8'b0001_0000,
		ST_ZERO  = 8'b0010_0000,
		ST_READ  = 8'b0100_0000,
		ST_RDATA = 8'b1000_0000
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic take;   // input may be accepted
		logic clr;    // clearing pass step
		logic put;    // execute put on cursor and cell
		logic blank;  // write blank at cursor
		logic copy;   // scroll copy step
		logic zero;   // scroll zero step
		logic rd;     // read address from item
		logic push;   // load result register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic cnt_last;   // sweep counter on last cell
		logic copy_last;  // scroll copy finished
		logic scroll;     // pending put runs off the last row
		logic out_free;   // result register can take a result
	} sts_t;

endpackage

@@ sv/tmcw_ram.sv @@
// Generic simple dual port RAM with registered read.
module tmcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1920
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ sv/tmcw_ctrl.sv @@
// Sequencing state machine for the console writer.
module tmcw_ctrl
	import tmcw_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [OP_W-1:0] in_op,
	input  sts_t            sts,
	output cmd_t            cmd
);

	state_t state_q, state_d;

	// next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.cnt_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.take = 1'b1;
				if (in_valid) begin
					state_d = (in_op == OP_READ) ? ST_READ : ST_PUT;
				end
			end
			ST_PUT: begin
				cmd.put = 1'b1;
				state_d = sts.scroll ? ST_COPY : ST_BLANK;
			end
			ST_BLANK: begin
				cmd.blank = 1'b1;
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_COPY: begin
				cmd.copy = 1'b1;
				if (sts.copy_last) begin
					state_d = ST_ZERO;
				end
			end
			ST_ZERO: begin
				cmd.zero = 1'b1;
				if (sts.cnt_last && sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_RDATA;
			end
			ST_RDATA: begin
				cmd.rd = 1'b1;
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register, clearing pass first after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ sv/tmcw_datapath.sv @@
// Cursor, attribute, screen store access and result register.
`include "text_mode_console_writer_defines.svh"

module tmcw_datapath
	import tmcw_pkg::*;
#(
	parameter int COLS = COLS_DEF,
	parameter int ROWS = ROWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              in_valid,
	input  logic [OP_W-1:0]   in_op,
	input  logic [CODE_W-1:0] in_code,
	input  logic [IDX_W-1:0]  in_idx,
	input  logic              cfg_valid,
	input  logic [ATTR_W-1:0] cfg_data,
	input  logic              m_tready,
	output logic              m_tvalid,
	output logic [CUR_W-1:0]  out_cursor,
	output logic [CELL_W-1:0] out_data,
	output logic              out_scrolled
);

	localparam int NCELLS = ROWS * COLS;
	localparam int AW     = $clog2(NCELLS);
	localparam int PW     = AW + 1;
	localparam int CW     = $clog2(COLS);
	localparam int RW     = $clog2(ROWS) + 1;
	localparam int IW     = (AW > IDX_W) ? AW : IDX_W;

	logic [OP_W-1:0]   op_q;
	logic [CODE_W-1:0] code_q;
	logic [IDX_W-1:0]  idx_q;
	logic [ATTR_W-1:0] attr_q;
	logic [CW-1:0]     col_q, col_d;
	logic [RW-1:0]     row_q, row_d;
	logic [AW-1:0]     cur_q;
	logic [PW-1:0]     pos_d;
	logic [AW-1:0]     cnt_q;
	logic              scr_q;
	logic              scroll_w;
	logic              is_char;
	logic [IW-1:0]     idx_ext;
	logic              in_range;
	logic              m_valid_q;
	logic [CUR_W-1:0]  out_cur_q;
	logic [CELL_W-1:0] out_data_q;
	logic              out_scr_q;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [CELL_W-1:0] ram_wdata, ram_rdata;
	logic [CELL_W-1:0] blank_cell;

	assign blank_cell = {attr_q, BLANK_CHAR};
	assign is_char    = (code_q != CODE_NEWLINE) && (code_q != CODE_BACKSPACE);
	assign idx_ext    = IW'(idx_q);
	assign in_range   = idx_ext < IW'(NCELLS);

	// cursor update for a put
	always_comb begin
		col_d = col_q;
		row_d = row_q;
		pos_d = PW'(cur_q);
		priority if (code_q == CODE_NEWLINE) begin
			col_d = '0;
			row_d = row_q + RW'(1);
			pos_d = PW'(cur_q) + PW'(COLS) - PW'(col_q);
		end else if (code_q == CODE_BACKSPACE) begin
			if (cur_q != '0) begin
				pos_d = PW'(cur_q) - PW'(1);
				if (col_q == '0) begin
					col_d = CW'(COLS - 1);
					row_d = row_q - RW'(1);
				end else begin
					col_d = col_q - CW'(1);
				end
			end
		end else begin
			pos_d = PW'(cur_q) + PW'(1);
			if (col_q == CW'(COLS - 1)) begin
				col_d = '0;
				row_d = row_q + RW'(1);
			end else begin
				col_d = col_q + CW'(1);
			end
		end
	end

	assign scroll_w = (row_d == RW'(ROWS));

	// attribute, cursor and scroll flag registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
			col_q  <= '0;
			row_q  <= '0;
			cur_q  <= '0;
			scr_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				attr_q <= cfg_data;
			end
			if (cmd.put) begin
				scr_q <= scroll_w;
				col_q <= col_d;
				if (scroll_w) begin
					row_q <= RW'(ROWS - 1);
					cur_q <= AW'(pos_d - PW'(COLS));
				end else begin
					row_q <= row_d;
					cur_q <= AW'(pos_d);
				end
			end
		end
	end

	// latched item payload
	always_ff @(posedge clk) begin
		if (cmd.take && in_valid) begin
			op_q   <= in_op;
			code_q <= in_code;
			idx_q  <= in_idx;
		end
	end

	// sweep counter for clearing and scrolling
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			priority if (cmd.clr) begin
				cnt_q <= cnt_q + AW'(1);
			end else if (cmd.put) begin
				cnt_q <= '0;
			end else if (cmd.copy) begin
				cnt_q <= sts.copy_last ? cur_q : cnt_q + AW'(1);
			end else if (cmd.zero) begin
				if (!sts.cnt_last) begin
					cnt_q <= cnt_q + AW'(1);
				end
			end else begin
				cnt_q <= cnt_q;
			end
		end
	end

	assign sts.cnt_last  = (cnt_q == AW'(NCELLS - 1));
	assign sts.copy_last = (cnt_q == AW'(NCELLS - COLS));
	assign sts.scroll    = scroll_w;
	assign sts.out_free  = !m_valid_q || m_tready;

	// screen store port selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = '0;
		ram_raddr = cnt_q;
		priority if (cmd.clr) begin
			ram_we = 1'b1;
		end else if (cmd.put) begin
			ram_we    = is_char;
			ram_waddr = cur_q;
			ram_wdata = {attr_q, code_q[CHAR_W-1:0]};
		end else if (cmd.blank) begin
			ram_we    = 1'b1;
			ram_waddr = cur_q;
			ram_wdata = blank_cell;
		end else if (cmd.copy) begin
			// read row below, write data fetched in the previous cycle
			ram_we    = (cnt_q != '0);
			ram_waddr = cnt_q - AW'(1);
			ram_wdata = ram_rdata;
			ram_raddr = cnt_q + AW'(COLS);
		end else if (cmd.zero) begin
			ram_we    = 1'b1;
			ram_wdata = (cnt_q == cur_q) ? blank_cell : '0;
		end else if (cmd.rd) begin
			ram_raddr = idx_ext[AW-1:0];
		end else begin
			ram_we = 1'b0;
		end
	end

	tmcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(NCELLS)
	) u_screen (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.push) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_cur_q <= CUR_W'(cur_q);
			if (op_q == OP_READ) begin
				out_data_q <= in_range ? ram_rdata : '0;
				out_scr_q  <= 1'b0;
			end else begin
				out_data_q <= '0;
				out_scr_q  <= scr_q;
			end
		end
	end

	assign m_tvalid     = m_valid_q;
	assign out_cursor   = out_cur_q;
	assign out_data     = out_data_q;
	assign out_scrolled = out_scr_q;

	// checks
	`TMCW_ASSERT(a_cursor_linear, 32'(cur_q) == 32'(row_q) * COLS + 32'(col_q), "cursor out of step")
	`TMCW_ASSERT(a_row_range, row_q < RW'(ROWS), "cursor row beyond screen")
	`TMCW_ASSERT(a_push_free, !cmd.push || !m_valid_q || m_tready, "result overwritten")
	`TMCW_ASSERT(a_waddr_range, !ram_we || (32'(ram_waddr) < NCELLS), "write beyond screen")
	`TMCW_ASSERT_NEXT(a_scroll_row, cmd.put && scroll_w, row_q == RW'(ROWS - 1) && col_q == '0, "scroll cursor wrong")

endmodule

@@ sv/text_mode_console_writer.sv @@
// Text mode console writer: put and read transactions on a character-cell screen.
//
// A put transaction (tuser 0) interprets a character code at the cursor and a read
// transaction (tuser 1) returns one screen cell; each gives one result transaction.
// Ordinary puts and reads go from acceptance to result through accept, store access
// and finish steps; a put writes its character and the blank at the new cursor in
// separate steps, as the screen RAM has a single write port. A put that runs off the
// last row scrolls the screen by sweeping the RAM one cell per cycle. After reset a
// clearing pass writes zero to all ROWS*COLS cells (1920 by default), during which no
// item is accepted; attribute writes are taken at any time and apply to later puts.
module text_mode_console_writer
	import tmcw_pkg::*;
#(
	parameter int COLS = COLS_DEF,
	parameter int ROWS = ROWS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // code[8:0], cell_index[19:9], zero pad
	input  logic [OP_W-1:0]       s_tuser,   // op
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // cursor_pos[10:0], read_data[26:11],
	                                         // scrolled[27], zero pad
	// attribute register write
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [ATTR_W-1:0]     cfg_data
);

	cmd_t              cmd;
	sts_t              sts;
	logic [CUR_W-1:0]  out_cursor;
	logic [CELL_W-1:0] out_data;
	logic              out_scrolled;

	assign s_tready  = cmd.take;
	assign cfg_ready = 1'b1;
	assign m_tdata   = {{(OUT_DATA_W - CUR_W - CELL_W - 1){1'b0}},
		out_scrolled, out_data, out_cursor};

	tmcw_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_op   (s_tuser),
		.sts     (sts),
		.cmd     (cmd)
	);

	tmcw_datapath #(
		.COLS(COLS),
		.ROWS(ROWS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_valid    (s_tvalid),
		.in_op       (s_tuser),
		.in_code     (s_tdata[CODE_W-1:0]),
		.in_idx      (s_tdata[CODE_W+IDX_W-1:CODE_W]),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.out_cursor  (out_cursor),
		.out_data    (out_data),
		.out_scrolled(out_scrolled)
	);

endmodule
